@@ rtl/core/xrb_pkg.sv @@
// Shared types, constants and helpers of the xoroshiro128+ random byte generator.
package xrb_pkg;

  localparam int MAX_BYTES_DEF = 512;
  localparam int CNT_W         = 10;
  localparam int WORD_W        = 64;
  localparam int HALF_W        = 32;
  localparam int VB_W          = 4;
  localparam int BYTES_PER_WORD = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [WORD_W-1:0] SEED_RESET = 64'h6368_6432_4D76_6931;
  localparam logic [WORD_W-1:0] GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_A      = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_B      = 64'h94D0_49BB_1331_11EB;

  localparam int ROT_A  = 55;
  localparam int SHL_B  = 14;
  localparam int ROT_C  = 36;
  localparam int MIX_S1 = 30;
  localparam int MIX_S2 = 27;
  localparam int MIX_S3 = 31;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_GEN
  } back_state_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // Rotate a 64-bit word left by a fixed amount
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amount);
    rotl = (v << amount) | (v >> (WORD_W - amount));
  endfunction

  // Build a mask that keeps the low n bytes of a word
  function automatic logic [WORD_W-1:0] byte_mask(input logic [VB_W-1:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      if (VB_W'(i) < n) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    byte_mask = m;
  endfunction

endpackage

@@ rtl/core/xrb_front.sv @@
// Request front end: accepts byte counts, saturates them and drops empty requests.
module xrb_front #(
  parameter int MAX_BYTES = xrb_pkg::MAX_BYTES_DEF,
  parameter int REM_W     = $clog2(MAX_BYTES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [xrb_pkg::CNT_W-1:0] byte_count,
  input  xrb_pkg::queue_status_t    q_status,
  output logic                      q_push,
  output logic [REM_W-1:0]          q_data
);
  import xrb_pkg::*;

  logic accept;
  logic busy;

  // Hold the producer off while the queue is full; hold one cycle out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign in_stall = q_status.full | busy;
  assign accept   = in_valid & ~in_stall;

  // Clamp the count and drop requests for zero bytes
  always_comb begin
    if (32'(byte_count) > MAX_BYTES) begin
      q_data = REM_W'(MAX_BYTES);
    end else begin
      q_data = REM_W'(byte_count);
    end
    q_push = accept & (byte_count != '0);
  end

endmodule

@@ rtl/core/xrb_queue.sv @@
// Short request queue between the front end and the generator.
module xrb_queue #(
  parameter int REM_W = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [REM_W-1:0]       push_data,
  input  logic                   pop,
  output logic [REM_W-1:0]       pop_data,
  output xrb_pkg::queue_status_t status
);
  import xrb_pkg::*;

  logic [REM_W-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data         = slots[rd_ptr];
  assign status.not_empty = (fill != '0);
  assign status.full      = (fill == QCNT_W'(QUEUE_DEPTH));

endmodule

@@ rtl/core/xrb_mul64.sv @@
// 64x64 low-half multiplier split into registered 32-bit partial products.
module xrb_mul64 (
  input  logic                       clk,
  input  logic [xrb_pkg::WORD_W-1:0] a,
  input  logic [xrb_pkg::WORD_W-1:0] b,
  output logic [xrb_pkg::WORD_W-1:0] prod
);
  import xrb_pkg::*;

  logic [WORD_W-1:0] pp_ll;
  logic [HALF_W-1:0] pp_hl;
  logic [HALF_W-1:0] pp_lh;
  logic [WORD_W-1:0] a_lo;
  logic [WORD_W-1:0] b_lo;
  logic [HALF_W-1:0] cross_sum;

  assign a_lo = {{HALF_W{1'b0}}, a[HALF_W-1:0]};
  assign b_lo = {{HALF_W{1'b0}}, b[HALF_W-1:0]};

  // Register the partial products; only the low half of the cross terms matters
  always_ff @(posedge clk) begin
    pp_ll <= a_lo * b_lo;
    pp_hl <= a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
    pp_lh <= a[HALF_W-1:0] * b[WORD_W-1:HALF_W];
  end

  // Combine them into the low 64 bits
  assign cross_sum = pp_hl + pp_lh;
  assign prod      = pp_ll + {cross_sum, {HALF_W{1'b0}}};

endmodule

@@ rtl/core/xrb_back.sv @@
// Generator back end: splitmix64 seeding sequencer, xoroshiro128+ step, output register.
module xrb_back #(
  parameter int MAX_BYTES = xrb_pkg::MAX_BYTES_DEF,
  parameter int REM_W     = $clog2(MAX_BYTES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [xrb_pkg::WORD_W-1:0] seed,
  input  logic                       seed_write,
  input  xrb_pkg::queue_status_t     q_status,
  input  logic [REM_W-1:0]           q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [xrb_pkg::WORD_W-1:0] random_word,
  output logic [xrb_pkg::VB_W-1:0]   valid_bytes,
  output logic                       last_word
);
  import xrb_pkg::*;

  back_state_t state, state_next;

  logic [WORD_W-1:0] state_low;
  logic [WORD_W-1:0] state_high;
  logic              seeded;
  logic [REM_W-1:0]  rem;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] z;
  logic              mix_sel;
  logic              half;

  logic [WORD_W-1:0] mul_in;
  logic [WORD_W-1:0] mul_k;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] mixed;

  logic              gen_fire;
  logic              is_last;
  logic [VB_W-1:0]   take;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] b_x;

  // Shared multiplier for both mixing rounds
  assign mul_in = mix_sel ? (z ^ (z >> MIX_S2)) : (z ^ (z >> MIX_S1));
  assign mul_k  = mix_sel ? MIX_B : MIX_A;
  assign mixed  = prod ^ (prod >> MIX_S3);

  xrb_mul64 u_mul (
    .clk  (clk),
    .a    (mul_in),
    .b    (mul_k),
    .prod (prod)
  );

  // Word step
  assign is_last = (rem <= REM_W'(BYTES_PER_WORD));
  assign take    = is_last ? VB_W'(rem) : VB_W'(BYTES_PER_WORD);
  assign sum     = state_low + state_high;
  assign b_x     = state_high ^ state_low;

  // Next state and handshake
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    gen_fire   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_status.not_empty) begin
          q_pop      = 1'b1;
          state_next = seeded ? BK_GEN : BK_MUL;
        end
      end
      BK_MUL: begin
        state_next = BK_SUM;
      end
      BK_SUM: begin
        if (mix_sel && half) begin
          state_next = BK_GEN;
        end else begin
          state_next = BK_MUL;
        end
      end
      BK_GEN: begin
        gen_fire = ~out_valid | ~out_stall;
        if (gen_fire && is_last) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Track seeding; a seed write forces a fresh expansion
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
    end else if (seed_write) begin
      seeded <= 1'b0;
    end else if (state == BK_SUM && mix_sel && half) begin
      seeded <= 1'b1;
    end
  end

  // Seeding datapath, remaining count and generator state
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_status.not_empty) begin
          rem     <= q_data;
          acc     <= seed + GOLDEN;
          z       <= seed + GOLDEN;
          mix_sel <= 1'b0;
          half    <= 1'b0;
        end
      end
      BK_SUM: begin
        if (!mix_sel) begin
          z       <= prod;
          mix_sel <= 1'b1;
        end else begin
          mix_sel <= 1'b0;
          half    <= 1'b1;
          acc     <= acc + GOLDEN;
          z       <= acc + GOLDEN;
          if (half) begin
            state_high <= mixed;
          end else begin
            state_low <= mixed;
          end
        end
      end
      BK_GEN: begin
        if (gen_fire) begin
          rem        <= rem - REM_W'(take);
          state_low  <= rotl(state_low, ROT_A) ^ b_x ^ (b_x << SHL_B);
          state_high <= rotl(b_x, ROT_C);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gen_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      random_word <= sum & byte_mask(take);
      valid_bytes <= take;
      last_word   <= is_last;
    end
  end

endmodule

@@ rtl/core/xoroshiro128p_random_bytes.sv @@
// An accepted request passes the queue, then the seeding sequencer when the state is unseeded,
//   then the generator step. The generator makes one word per cycle while the output is not
//   stalled and handles one request at a time; the seeding sequencer shares one split multiplier.
// Requests queue two deep in front of the generator; zero-byte requests are dropped.
// Reset (rst, synchronous): seed returns to its default, state is marked unseeded,
//   queue and output register empty; input is stalled for the first cycle after reset.
module xoroshiro128p_random_bytes #(
  parameter int MAX_BYTES = xrb_pkg::MAX_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [xrb_pkg::CNT_W-1:0]  byte_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [xrb_pkg::WORD_W-1:0] random_word,
  output logic [xrb_pkg::VB_W-1:0]   valid_bytes,
  output logic                       last_word,
  input  logic                       seed_valid,
  output logic                       seed_ready,
  input  logic [xrb_pkg::WORD_W-1:0] seed_value
);
  import xrb_pkg::*;

  localparam int REM_W = $clog2(MAX_BYTES + 1);

  logic [WORD_W-1:0] seed;
  logic              seed_write;
  queue_status_t     q_status;
  logic              q_push;
  logic              q_pop;
  logic [REM_W-1:0]  q_in;
  logic [REM_W-1:0]  q_out;

  // Seed register
  assign seed_ready = 1'b1;
  assign seed_write = seed_valid & seed_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_write) begin
      seed <= seed_value;
    end
  end

  xrb_front #(
    .MAX_BYTES (MAX_BYTES),
    .REM_W     (REM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_count (byte_count),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  xrb_queue #(
    .REM_W (REM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  xrb_back #(
    .MAX_BYTES (MAX_BYTES),
    .REM_W     (REM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .seed        (seed),
    .seed_write  (seed_write),
    .q_status    (q_status),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word)
  );

  // Byte counts on output words stay in range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_bytes != '0) && (valid_bytes <= VB_W'(BYTES_PER_WORD)))
    else $error("valid_bytes out of range");

  // Only the final word of a request may be partial
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_word |-> valid_bytes == VB_W'(BYTES_PER_WORD))
    else $error("partial word before end of request");

  // Bytes beyond valid_bytes are cleared
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (random_word & ~byte_mask(valid_bytes)) == '0)
    else $error("unused bytes not zero");

  // Queue never pops when empty
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.not_empty)
    else $error("pop from empty request queue");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the xoroshiro128+ random byte generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xrb_pkg::*;

  localparam logic [63:0] SPLIT_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SPLIT_MUL1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SPLIT_MUL2 = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] SEED_AT_RESET = 64'h6368_6432_4D76_6931;
  localparam int REQ_LIMIT = 512;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 100;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [VB_W-1:0]   vbytes;
    logic              last;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CNT_W-1:0] byte_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WORD_W-1:0] random_word;
  logic [VB_W-1:0] valid_bytes;
  logic last_word;
  logic seed_valid = 1'b0;
  logic seed_ready;
  logic [WORD_W-1:0] seed_value = '0;

  // Generator copy kept by the predictor
  logic [63:0] gen_lo = '0;
  logic [63:0] gen_hi = '0;
  logic        gen_seeded = 1'b0;
  logic [63:0] gen_seed = SEED_AT_RESET;

  logic [CNT_W-1:0] pending_counts[$];
  word_t            expected_words[$];
  int offered_cnt = 0;
  int taken_cnt = 0;
  int fail_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_block = 1'b0;

  xoroshiro128p_random_bytes DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_count  (byte_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word),
    .seed_valid  (seed_valid),
    .seed_ready  (seed_ready),
    .seed_value  (seed_value)
  );

  always #4 clk = ~clk;

  // splitmix64 output mixing
  function automatic logic [63:0] splitmix_mix(input logic [63:0] z);
    logic [63:0] t;
    t = (z ^ (z >> 30)) * SPLIT_MUL1;
    t = (t ^ (t >> 27)) * SPLIT_MUL2;
    return t ^ (t >> 31);
  endfunction

  // One xoroshiro128+ step, seeding first when needed
  function automatic logic [63:0] xoro_next_word();
    logic [63:0] acc, a, b, sum;
    if (!gen_seeded) begin
      acc = gen_seed + SPLIT_STEP;
      gen_lo = splitmix_mix(acc);
      acc = acc + SPLIT_STEP;
      gen_hi = splitmix_mix(acc);
      gen_seeded = 1'b1;
    end
    a = gen_lo;
    b = gen_hi;
    sum = a + b;
    b = b ^ a;
    gen_lo = {a[8:0], a[63:9]} ^ b ^ (b << 14);
    gen_hi = {b[27:0], b[63:28]};
    return sum;
  endfunction

  // Expand one request into the words it must produce
  function automatic void predict_request(input logic [CNT_W-1:0] cnt);
    int left, take;
    word_t w;
    left = (int'(cnt) > REQ_LIMIT) ? REQ_LIMIT : int'(cnt);
    while (left > 0) begin
      take = (left >= 8) ? 8 : left;
      w.word = xoro_next_word();
      if (take < 8) w.word = w.word & ((64'd1 << (take * 8)) - 64'd1);
      left = left - take;
      w.vbytes = VB_W'(take);
      w.last = (left == 0);
      expected_words.push_back(w);
    end
  endfunction

  // Request sender: hold a stalled item, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && offered_cnt != taken_cnt) begin
      in_valid <= 1'b1;
    end else if (pending_counts.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
      byte_count <= pending_counts.pop_front();
      in_valid <= 1'b1;
      offered_cnt++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver stall
  always @(negedge clk) begin
    out_stall <= rx_block || ($urandom_range(99) < rx_idle_pct);
  end

  // Predict on accepted requests, check accepted words
  always @(posedge clk) begin : monitor
    word_t got, want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_request(byte_count);
        taken_cnt++;
      end
      if (out_valid && !out_stall) begin
        got = '{random_word, valid_bytes, last_word};
        if (expected_words.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected word %h valid_bytes %0d last %0b",
                     got.word, got.vbytes, got.last);
          fail_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (fail_cnt < 10)
              $display("word mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                       want.word, want.vbytes, want.last,
                       got.word, got.vbytes, got.last);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Long receiver hold-off while requests keep coming, so the queue backs up
  initial begin
    while (taken_cnt < 160) @(posedge clk);
    rx_block = 1'b1;
    repeat (300) @(posedge clk);
    rx_block = 1'b0;
  end

  // Hard stop
  initial begin
    #8_000_000;
    $display("xoroshiro128p_random_bytes verification failed");
    $finish;
  end

  // Random byte count, mostly short requests
  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 78) return CNT_W'($urandom_range(40, 1));
    if (r < 92) return CNT_W'($urandom_range(200, 41));
    if (r < 97) return CNT_W'($urandom_range(512, 201));
    return CNT_W'($urandom_range(1023, 513));
  endfunction

  // Wait until every request is taken and every word has come back
  task automatic wait_drained();
    while (pending_counts.size() > 0 || offered_cnt != taken_cnt ||
           expected_words.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the seed register; only called with the block idle
  task automatic write_seed(input logic [63:0] v);
    @(negedge clk);
    seed_valid <= 1'b1;
    seed_value <= v;
    do @(posedge clk); while (!seed_ready);
    gen_seed = v;
    gen_seeded = 1'b0;
    @(negedge clk);
    seed_valid <= 1'b0;
  endtask

  // Fill the queue with random requests under one idling mix
  task automatic random_phase(input int tx, input int rx);
    @(posedge clk);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    repeat (RANDOM_ITEMS) pending_counts.push_back(pick_count());
    wait_drained();
  endtask

  initial begin
    int directed[];
    directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 15, 16, 17, 24, 31, 32, 33,
                 64, 511, 512, 513, 1023, 0, 1000, 4};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the count under the reset seed
    foreach (directed[i]) pending_counts.push_back(CNT_W'(directed[i]));
    wait_drained();

    // All-ones seed; a zero request must not trigger seeding
    write_seed('1);
    pending_counts.push_back('0);
    pending_counts.push_back(CNT_W'(3));
    random_phase(0, 0);

    write_seed('0);
    random_phase(46, 0);

    // Back-to-back seed writes, only the last one counts
    write_seed({$urandom, $urandom});
    write_seed({$urandom, $urandom});
    random_phase(0, 46);

    write_seed(SEED_AT_RESET);
    random_phase(38, 38);

    if (fail_cnt == 0 && expected_words.size() == 0) begin
      $display("xoroshiro128p_random_bytes verification clean");
    end else begin
      $display("xoroshiro128p_random_bytes verification failed");
    end
    $finish;
  end

endmodule
